[hw/rtl/dte_pkg.sv]
// dte_pkg: widths, register codes, increment constants and the sine table
// for the dds tone envelope block. No dependencies; used by every rtl file.
package dte_pkg;

  localparam int unsigned SINE_ENTRIES = 256;
  localparam int unsigned SAMPLE_RATE  = 50000;

  localparam int unsigned FREQ_W   = 12;
  localparam int unsigned CNT_W    = 17;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned AMP_W    = 18;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned ROM_W    = 27;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SMP_W    = 12;
  localparam int unsigned DAC_W    = 16;
  localparam int unsigned NOTE_W   = 2;
  localparam int unsigned NOTES    = 4;

  localparam int unsigned RAD_W    = 24;
  localparam int unsigned ROOT_W   = 12;
  localparam int unsigned SQRT_SCALE = 100;

  localparam int unsigned IDX_W    = $clog2(SINE_ENTRIES);
  localparam int unsigned ENT_W    = $clog2(SINE_ENTRIES + 1);
  localparam int unsigned PROD_W   = AMP_W + ROM_W;
  localparam int unsigned SAMPLE_SH = 30;

  localparam logic [SMP_W-1:0] SAMPLE_OFFSET = 12'd2048;
  localparam logic [DAC_W-1:0] DAC_CTRL      = 16'hB000;

  // phase increment floor(f*2^32/rate) = f*A + floor(f*B/rate)
  localparam longint unsigned INCR_A   = (64'd1 << PHASE_W) / SAMPLE_RATE;
  localparam longint unsigned INCR_B   = (64'd1 << PHASE_W) % SAMPLE_RATE;
  localparam int unsigned     INCR_A_W = $clog2(INCR_A + 1);
  localparam int unsigned     SR_W     = $clog2(SAMPLE_RATE);
  localparam int unsigned     RECIP_SH = FREQ_W + 2 * SR_W;
  localparam longint unsigned RECIP    =
      ((64'd1 << RECIP_SH) + SAMPLE_RATE - 1) / SAMPLE_RATE;
  localparam int unsigned     RECIP_W  = $clog2(RECIP + 1);
  localparam int unsigned     PA_W     = FREQ_W + INCR_A_W;
  localparam int unsigned     PB_W     = FREQ_W + SR_W;
  localparam int unsigned     PC_W     = PB_W + RECIP_W;

  localparam logic [1:0] MODE_NOTES  = 2'd2;
  localparam logic [1:0] MODE_SILENT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_NOTE_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd7;

  typedef struct packed {
    logic [NOTE_W-1:0]  note;
    logic [TICK_W-1:0]  tick;
    logic [AMP_W-1:0]   amp;
    logic [PHASE_W-1:0] phase;
  } dte_state_t;

  typedef logic signed [ROM_W-1:0] sine_tab_t [SINE_ENTRIES];

  localparam longint unsigned PI_Q60    = 64'h3243F6A8885A308D;
  localparam longint unsigned ROM_SCALE = 2047 * 32768;
  localparam longint unsigned ROM_DEN   = 1000 * SINE_ENTRIES;

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int unsigned sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return p[63:0];
  endfunction

  function automatic logic signed [ROM_W-1:0] rom_entry(int unsigned i);
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] s;
    logic        neg;
    int          k;
    num  = 64'(i) * 64'd6283;
    q    = num / ROM_DEN;
    r    = num % ROM_DEN;
    frac = 64'd0;
    neg  = 1'b0;
    for (k = 0; k < 60; k++) begin
      r    = r << 1;
      frac = frac << 1;
      if (r >= ROM_DEN) begin
        r       = r - ROM_DEN;
        frac[0] = 1'b1;
      end
    end
    x = (q << 60) | frac;
    if (x >= PI_Q60) begin
      x   = x - PI_Q60;
      neg = 1'b1;
    end
    if (x > (PI_Q60 >> 1)) x = PI_Q60 - x;
    t = x;
    s = x;
    for (k = 1; k < 30 && t != 64'd0; k++) begin
      t = mul_shift(mul_shift(t, x, 60), x, 60) / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) s = s - t;
      else s = s + t;
    end
    t = mul_shift(s, ROM_SCALE, 60);
    return neg ? -ROM_W'(t) : ROM_W'(t);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int unsigned i = 0; i < SINE_ENTRIES; i++) tab[i] = rom_entry(i);
    return tab;
  endfunction

  localparam sine_tab_t SINE_ROM = build_sine();

endpackage

[hw/rtl/dte_isqrt.sv]
// dte_isqrt: iterative integer square root, one result bit per cycle.
// Depends on dte_pkg for the radicand and root widths.
module dte_isqrt import dte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned ITER_W = $clog2(ROOT_W);
  localparam int unsigned REM_W  = ROOT_W + 2;

  logic              busy_q;
  logic [ITER_W-1:0] iter_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              ge;

  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      iter_q <= '0;
    end else if (busy_q) begin
      iter_q <= iter_q + 1'b1;
      if (iter_q == ITER_W'(ROOT_W - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

[hw/rtl/dds_tone_envelope.sv]
// dds_tone_envelope: dds sine tone with linear attack and decay envelope.
// Depends on dte_pkg and dte_isqrt.
//
// Each input word on in_valid_i/in_stall_o is one sample tick. Mode 0 or 1
// plays floor(10*sqrt(live_cell_count_i)) hertz, mode 2 steps through the
// four note registers one beep at a time, mode 3 is taken and dropped with
// no output word and no state change.
// One word is worked on at a time: in_stall_o is high from acceptance until
// the result is loaded into the output register. In modes 0 and 1 a word
// waits for the square root unit, and every word then passes through the
// registered multiply, sine rom and state memory stages.
// The result waits in an output register while out_stall_i is high; a new
// word is taken meanwhile, and it holds in the last stage until the register
// frees. Configuration writes on cfg_we_i apply at once; the user must make
// them only while the block is idle, as the block does not enforce it.
// Reset loads the register defaults and marks the one-entry state memory
// invalid, so phase, amplitude, tick count and note index read as zero.
module dds_tone_envelope import dte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           mode_i,
  input  logic [CNT_W-1:0]     live_cell_count_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DAC_W-1:0]     dac_word_o,
  output logic [SMP_W-1:0]     sample_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FREQ  = 4'd1;
  localparam logic [3:0] ST_MUL1  = 4'd2;
  localparam logic [3:0] ST_MUL2  = 4'd3;
  localparam logic [3:0] ST_PHASE = 4'd4;
  localparam logic [3:0] ST_IDX   = 4'd5;
  localparam logic [3:0] ST_ROM   = 4'd6;
  localparam logic [3:0] ST_PROD  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0] state_q, state_d;

  logic [FREQ_W-1:0] note_q [NOTES];
  logic [TICK_W-1:0] beep_q, attack_q, decay_q;
  logic [CFG_W-1:0]  step_q;

  logic                    in_acc;
  logic [1:0]              mode_q;
  logic                    sq_start;
  logic                    sq_busy;
  logic [ROOT_W-1:0]       sq_root;
  logic [RAD_W-1:0]        sq_rad;

  logic [FREQ_W-1:0]         freq_q;
  logic [PA_W-1:0]           pa_q;
  logic [PB_W-1:0]           pb_q;
  logic [PC_W-1:0]           pc_q;
  logic [PHASE_W-1:0]        phase_q;
  logic [PHASE_W+ENT_W-1:0]  idx_prod_q;
  logic signed [ROM_W-1:0]   rom_q;
  logic signed [PROD_W-1:0]  prod_q;

  dte_state_t state_mem [1];
  dte_state_t st_rd_q;
  logic       st_vld_q;
  dte_state_t st_cur;
  dte_state_t st_wr;
  logic       st_we;

  logic                   out_load;
  logic                   out_vld_q;
  logic [SMP_W-1:0]       smp_q;
  logic [SMP_W-1:0]       smp_d;

  logic [AMP_W-1:0]       amp_n;
  logic [TICK_W-1:0]      tick_n;
  logic signed [AMP_W-1:0] thr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sq_start   = in_acc && (mode_i != MODE_SILENT) && (mode_i != MODE_NOTES);
  assign sq_rad     = RAD_W'(live_cell_count_i) * RAD_W'(SQRT_SCALE);

  dte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (sq_rad),
    .busy_o (sq_busy),
    .root_o (sq_root)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_q[0] <= 12'd261;
      note_q[1] <= 12'd293;
      note_q[2] <= 12'd329;
      note_q[3] <= 12'd392;
      beep_q    <= 16'd6500;
      attack_q  <= 16'd250;
      decay_q   <= 16'd250;
      step_q    <= 16'd131;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NOTE_0: note_q[0] <= cfg_data_i[FREQ_W-1:0];
        REG_NOTE_1: note_q[1] <= cfg_data_i[FREQ_W-1:0];
        REG_NOTE_2: note_q[2] <= cfg_data_i[FREQ_W-1:0];
        REG_NOTE_3: note_q[3] <= cfg_data_i[FREQ_W-1:0];
        REG_BEEP:   beep_q    <= cfg_data_i;
        REG_ATTACK: attack_q  <= cfg_data_i;
        REG_DECAY:  decay_q   <= cfg_data_i;
        REG_STEP:   step_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc && mode_i != MODE_SILENT) state_d = ST_FREQ;
      ST_FREQ:  if (!sq_busy) state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_PHASE;
      ST_PHASE: state_d = ST_IDX;
      ST_IDX:   state_d = ST_ROM;
      ST_ROM:   state_d = ST_PROD;
      ST_PROD:  state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // state memory, one entry, registered read
  assign st_cur = st_vld_q ? st_rd_q : '0;
  assign st_we  = (state_q == ST_PROD);

  always_ff @(posedge clk_i) begin
    if (st_we) state_mem[0] <= st_wr;
    st_rd_q <= state_mem[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_vld_q <= 1'b0;
    else if (st_we) st_vld_q <= 1'b1;
  end

  // envelope and tick update
  always_comb begin
    thr    = $signed({2'b00, beep_q}) - $signed({2'b00, decay_q});
    amp_n  = st_cur.amp;
    if (st_cur.tick < attack_q) amp_n = st_cur.amp + AMP_W'(step_q);
    else if ($signed({2'b00, st_cur.tick}) > thr) amp_n = st_cur.amp - AMP_W'(step_q);
    tick_n = st_cur.tick + 1'b1;
    st_wr.phase = phase_q;
    st_wr.note  = st_cur.note;
    if (tick_n == beep_q) begin
      tick_n = '0;
      amp_n  = '0;
      if (mode_q == MODE_NOTES) st_wr.note = st_cur.note + 1'b1;
    end
    st_wr.amp  = amp_n;
    st_wr.tick = tick_n;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) mode_q <= mode_i;
    case (state_q)
      ST_FREQ:  freq_q <= (mode_q == MODE_NOTES) ? note_q[st_cur.note] : sq_root;
      ST_MUL1: begin
        pa_q <= PA_W'(freq_q) * PA_W'(INCR_A);
        pb_q <= PB_W'(freq_q) * PB_W'(INCR_B);
      end
      ST_MUL2:  pc_q <= PC_W'(pb_q) * PC_W'(RECIP);
      ST_PHASE: phase_q <= st_cur.phase + PHASE_W'(pa_q) + PHASE_W'(pc_q >> RECIP_SH);
      ST_IDX:   idx_prod_q <= (PHASE_W + ENT_W)'(phase_q) * (PHASE_W + ENT_W)'(SINE_ENTRIES);
      ST_ROM:   rom_q <= SINE_ROM[idx_prod_q[PHASE_W +: IDX_W]];
      ST_PROD:  prod_q <= $signed(st_cur.amp) * rom_q;
      default: ;
    endcase
  end

  // output register
  assign out_load = (state_q == ST_OUT) && (!out_vld_q || !out_stall_i);
  assign smp_d    = prod_q[SAMPLE_SH +: SMP_W] + SAMPLE_OFFSET;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (out_load) out_vld_q <= 1'b1;
    else if (!out_stall_i) out_vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) smp_q <= smp_d;
  end

  assign out_valid_o = out_vld_q;
  assign sample_o    = smp_q;
  assign dac_word_o  = DAC_CTRL | DAC_W'(smp_q);

  a_silent_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && mode_i == MODE_SILENT |=> state_q == ST_IDLE)
    else $error("silent word started the sequencer");

  a_sqrt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !sq_busy)
    else $error("square root busy while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && out_vld_q && out_stall_i |=> state_q == ST_OUT && $stable(smp_q))
    else $error("pending word overwritten");

  a_dac_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> dac_word_o[SMP_W-1:0] == sample_o && dac_word_o[DAC_W-1:SMP_W] == 4'hB)
    else $error("dac word does not match sample");

  a_state_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |=> st_vld_q && state_q == ST_OUT)
    else $error("state write out of sequence");

endmodule
